### rtl/core/mrft_pkg.sv
// Shared types and codes for the marked record FIFO tracker.
package mrft_pkg;

    // Function codes of an input word
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_FETCH  = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UNMARK = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_NOROOM  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_BYTES    = 2'd0;
    localparam logic [1:0] CFG_SHRINK_BYTES = 2'd1;

    localparam int IN_W  = 56;
    localparam int OUT_W = 104;
    localparam int CFG_W = 24;

    // Scan modes
    typedef enum logic [1:0] {
        SCAN_EVICT,
        SCAN_FETCH,
        SCAN_BUCKET
    } scan_mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_run;
        scan_mode_t mode;
        logic       trim_head;
        logic       trim_tail;
        logic       add;
        logic       finish;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       need_evict;
        logic       scan_done;
        logic       head_hole;
        logic       tail_hole;
        logic       out_free;
    } dp_stat_t;

endpackage

### rtl/core/mrft_ctrl.sv
// Sequencing state machine of the marked record FIFO tracker.
module mrft_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  mrft_pkg::dp_stat_t stat,
    output mrft_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_TRIM_HEAD,
        ST_TRIM_TAIL,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    mrft_pkg::scan_mode_t mode_reg;
    mrft_pkg::scan_mode_t mode_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                unique case (stat.func)
                    mrft_pkg::FUNC_ADD:
                    begin
                        if (stat.need_evict)
                        begin
                            state_next = ST_SCAN;
                            mode_next  = mrft_pkg::SCAN_EVICT;
                        end
                        else
                            state_next = ST_ADD;
                    end
                    mrft_pkg::FUNC_FETCH:
                    begin
                        state_next = ST_SCAN;
                        mode_next  = mrft_pkg::SCAN_FETCH;
                    end
                    default:
                    begin
                        state_next = ST_SCAN;
                        mode_next  = mrft_pkg::SCAN_BUCKET;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (mode_reg == mrft_pkg::SCAN_FETCH ||
                        stat.func == mrft_pkg::FUNC_UNMARK)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_TRIM_HEAD;
                end
            end
            ST_TRIM_HEAD:
            begin
                if (!stat.head_hole)
                    state_next = ST_TRIM_TAIL;
            end
            ST_TRIM_TAIL:
            begin
                if (!stat.tail_hole)
                    state_next = (stat.func == mrft_pkg::FUNC_ADD) ? ST_ADD : ST_FINISH;
            end
            ST_ADD:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= mrft_pkg::SCAN_EVICT;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // Command decode
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.mode       = mode_reg;
        cmd.load       = in_fire;
        cmd.scan_start = (state_reg == ST_DISPATCH);
        cmd.scan_run   = (state_reg == ST_SCAN);
        cmd.trim_head  = (state_reg == ST_TRIM_HEAD);
        cmd.trim_tail  = (state_reg == ST_TRIM_TAIL);
        cmd.add        = (state_reg == ST_ADD);
        cmd.finish     = (state_reg == ST_FINISH) && stat.out_free;
    end

endmodule

### rtl/core/mrft_dp.sv
// Datapath of the marked record FIFO tracker: ring store, totals, scan and result.
module mrft_dp
#(
    parameter int ENTRY_DEPTH = 64,
    parameter int SIZE_BITS   = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mrft_pkg::IN_W-1:0]   in_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [mrft_pkg::CFG_W-1:0]  cfg_data,
    input  mrft_pkg::dp_cmd_t           cmd,
    output mrft_pkg::dp_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mrft_pkg::OUT_W-1:0]  out_data
);

    localparam int AW    = (ENTRY_DEPTH > 2) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
    localparam int OCC_W = SIZE_BITS + CNT_W;
    localparam int CMP_W = (OCC_W >= 24) ? OCC_W + 1 : 25;

    // Slot arithmetic on the ring
    function automatic logic [AW-1:0] wrap(input logic [CNT_W-1:0] a,
                                           input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= (CNT_W+1)'(ENTRY_DEPTH))
                sum = sum - (CNT_W+1)'(ENTRY_DEPTH);
            wrap = sum[AW-1:0];
        end
    endfunction

    // Storage
    logic [SIZE_BITS-1:0] mem_size [ENTRY_DEPTH];
    logic [15:0]          mem_bucket [ENTRY_DEPTH];
    logic [ENTRY_DEPTH-1:0] valid_reg;
    logic [ENTRY_DEPTH-1:0] marked_reg;

    logic [23:0]          max_reg;
    logic [23:0]          shrink_reg;
    logic [AW-1:0]        head_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     ub_reg;
    logic [CNT_W-1:0]     ur_reg;

    // Latched item
    logic [1:0]           func_reg;
    logic [SIZE_BITS-1:0] rsize_reg;
    logic [15:0]          bucket_reg;
    logic [15:0]          blen_reg;

    // Scan pipeline
    logic [CNT_W-1:0]     k_reg;
    logic                 pv_reg;
    logic [AW-1:0]        pslot_reg;
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic [15:0]          rd_bucket_reg;
    logic                 found_reg;
    logic                 hit_reg;

    // Result
    logic [1:0]           status_reg;
    logic [SIZE_BITS-1:0] osize_reg;
    logic [15:0]          obucket_reg;
    logic [AW-1:0]        oslot_reg;
    logic [CNT_W-1:0]     evicted_reg;
    logic                 out_valid_reg;
    logic [mrft_pkg::OUT_W-1:0] out_data_reg;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        tail_slot;
    logic [AW-1:0]        last_slot;
    logic                 over_shrink;
    logic                 scan_stop;
    logic                 issue;
    logic [CMP_W-1:0]     need_sum;
    logic                 p_valid;
    logic                 p_marked;

    assign rd_addr     = wrap(CNT_W'(head_reg), k_reg);
    assign tail_slot   = wrap(CNT_W'(head_reg), fill_reg);
    assign last_slot   = wrap(CNT_W'(head_reg), fill_reg - CNT_W'(1));
    assign over_shrink = CMP_W'(occ_reg) > CMP_W'(shrink_reg);
    assign need_sum    = CMP_W'(occ_reg) + CMP_W'(rsize_reg);
    assign p_valid     = valid_reg[pslot_reg];
    assign p_marked    = marked_reg[pslot_reg];

    // Scan stop conditions
    always_comb
    begin
        scan_stop = 1'b0;
        if (cmd.mode == mrft_pkg::SCAN_EVICT)
            scan_stop = !over_shrink;
        else if (cmd.mode == mrft_pkg::SCAN_FETCH)
            scan_stop = found_reg;
    end
    assign issue = cmd.scan_run && !scan_stop && (k_reg < fill_reg);

    always_comb
    begin
        stat            = '0;
        stat.func       = func_reg;
        stat.need_evict = (max_reg != 24'd0) && (need_sum > CMP_W'(max_reg));
        stat.scan_done  = scan_stop || (!pv_reg && k_reg == fill_reg);
        stat.head_hole  = (fill_reg != '0) && !valid_reg[head_reg];
        stat.tail_hole  = (fill_reg != '0) && !valid_reg[last_slot];
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= '0;
            shrink_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mrft_pkg::CFG_MAX_BYTES)
                max_reg <= cfg_data;
            else if (cfg_index == mrft_pkg::CFG_SHRINK_BYTES)
                shrink_reg <= cfg_data;
        end
    end

    // Record memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.add && fill_reg < CNT_W'(ENTRY_DEPTH))
        begin
            mem_size[tail_slot]   <= rsize_reg;
            mem_bucket[tail_slot] <= bucket_reg;
        end
        rd_size_reg   <= mem_size[rd_addr];
        rd_bucket_reg <= mem_bucket[rd_addr];
    end

    // Latched item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_data[1:0];
            rsize_reg  <= SIZE_BITS'({16'd0, in_data[17:2]});
            bucket_reg <= in_data[33:18];
            blen_reg   <= in_data[49:34];
            status_reg <= (in_data[1:0] == mrft_pkg::FUNC_ADD) ? mrft_pkg::STAT_OK
                                                                : mrft_pkg::STAT_MISS;
            osize_reg  <= '0;
            obucket_reg <= '0;
            oslot_reg  <= '0;
        end
        else if (cmd.scan_run && pv_reg && cmd.mode == mrft_pkg::SCAN_FETCH &&
                 !found_reg && p_valid && !p_marked)
        begin
            osize_reg   <= rd_size_reg;
            obucket_reg <= rd_bucket_reg;
            oslot_reg   <= pslot_reg;
            status_reg  <= (32'(rd_size_reg) > 32'(blen_reg)) ? mrft_pkg::STAT_NOROOM
                                                              : mrft_pkg::STAT_OK;
        end
        else if (cmd.scan_run && stat.scan_done && cmd.mode == mrft_pkg::SCAN_BUCKET)
            status_reg <= hit_reg ? mrft_pkg::STAT_OK : mrft_pkg::STAT_MISS;
        else if (cmd.add)
        begin
            if (fill_reg < CNT_W'(ENTRY_DEPTH))
                oslot_reg <= tail_slot;
            else
                status_reg <= mrft_pkg::STAT_FULL;
        end
    end

    // Ring state, totals and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            marked_reg  <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            occ_reg     <= '0;
            ub_reg      <= '0;
            ur_reg      <= '0;
            k_reg       <= '0;
            pv_reg      <= 1'b0;
            pslot_reg   <= '0;
            found_reg   <= 1'b0;
            hit_reg     <= 1'b0;
            evicted_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                evicted_reg <= '0;
            if (cmd.scan_start)
            begin
                k_reg     <= '0;
                pv_reg    <= 1'b0;
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pv_reg    <= issue;
                pslot_reg <= rd_addr;
                if (issue)
                    k_reg <= k_reg + CNT_W'(1);
                // process the slot read last cycle
                if (pv_reg)
                begin
                    unique case (cmd.mode)
                        mrft_pkg::SCAN_EVICT:
                        begin
                            if (over_shrink && p_valid)
                            begin
                                occ_reg <= occ_reg - OCC_W'(rd_size_reg);
                                if (!p_marked)
                                begin
                                    ub_reg <= ub_reg - OCC_W'(rd_size_reg);
                                    ur_reg <= ur_reg - CNT_W'(1);
                                end
                                valid_reg[pslot_reg]  <= 1'b0;
                                marked_reg[pslot_reg] <= 1'b0;
                                evicted_reg <= evicted_reg + CNT_W'(1);
                            end
                        end
                        mrft_pkg::SCAN_FETCH:
                        begin
                            if (!found_reg && p_valid && !p_marked)
                            begin
                                found_reg <= 1'b1;
                                if (32'(rd_size_reg) <= 32'(blen_reg))
                                begin
                                    marked_reg[pslot_reg] <= 1'b1;
                                    ub_reg <= ub_reg - OCC_W'(rd_size_reg);
                                    ur_reg <= ur_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (p_valid && p_marked && rd_bucket_reg == bucket_reg)
                            begin
                                hit_reg <= 1'b1;
                                marked_reg[pslot_reg] <= 1'b0;
                                if (func_reg == mrft_pkg::FUNC_REMOVE)
                                begin
                                    occ_reg <= occ_reg - OCC_W'(rd_size_reg);
                                    valid_reg[pslot_reg] <= 1'b0;
                                end
                                else
                                begin
                                    ub_reg <= ub_reg + OCC_W'(rd_size_reg);
                                    ur_reg <= ur_reg + CNT_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            // drop holes at the ends of the span
            if (cmd.trim_head && stat.head_hole)
            begin
                head_reg <= wrap(CNT_W'(head_reg), CNT_W'(1));
                fill_reg <= fill_reg - CNT_W'(1);
            end
            if (cmd.trim_tail && stat.tail_hole)
                fill_reg <= fill_reg - CNT_W'(1);
            // append a record
            if (cmd.add && fill_reg < CNT_W'(ENTRY_DEPTH))
            begin
                valid_reg[tail_slot]  <= 1'b1;
                marked_reg[tail_slot] <= 1'b0;
                fill_reg <= fill_reg + CNT_W'(1);
                occ_reg  <= occ_reg + OCC_W'(rsize_reg);
                ub_reg   <= ub_reg + OCC_W'(rsize_reg);
                ur_reg   <= ur_reg + CNT_W'(1);
            end
        end
    end

    // Saturated totals
    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] ub_ext;
    logic [15:0]      ur_ext;
    logic [15:0]      ev_ext;
    logic [23:0]      occ_sat;
    logic [23:0]      ub_sat;
    logic [6:0]       ur_sat;
    logic [6:0]       ev_sat;
    logic [31:0]      osize_ext;
    logic [15:0]      oslot_ext;

    assign occ_ext   = CMP_W'(occ_reg);
    assign ub_ext    = CMP_W'(ub_reg);
    assign ur_ext    = 16'(ur_reg);
    assign ev_ext    = 16'(evicted_reg);
    assign occ_sat   = (occ_ext > CMP_W'(24'hFFFFFF)) ? 24'hFFFFFF : occ_ext[23:0];
    assign ub_sat    = (ub_ext > CMP_W'(24'hFFFFFF)) ? 24'hFFFFFF : ub_ext[23:0];
    assign ur_sat    = (ur_ext > 16'd127) ? 7'd127 : ur_ext[6:0];
    assign ev_sat    = (ev_ext > 16'd127) ? 7'd127 : ev_ext[6:0];
    assign osize_ext = 32'(osize_reg);
    assign oslot_ext = 16'(oslot_reg);

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= {2'b00, occ_sat, ur_sat, ub_sat, ev_sat, oslot_ext[5:0],
                             obucket_reg, osize_ext[15:0], status_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRY_DEPTH))
        else $error("ring fill beyond depth");
    a_unmarked_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ur_reg <= fill_reg)
        else $error("unmarked count exceeds fill");
    a_bytes_order: assert property (@(posedge clk) disable iff (!rst_n)
        ub_reg <= occ_reg)
        else $error("unmarked bytes exceed occupied bytes");
`endif

endmodule

### rtl/core/marked_record_fifo_tracker.sv
// Top level of the marked record FIFO tracker.
// Usage:
//   s_axis carries one request word: func, record_size, bucket_tag, offer_len.
//   m_axis returns one result word per request with status, the fetched or
//   added record, the eviction count and the running totals.
//   cfg_we/cfg_index/cfg_data write the byte limit (0) and shrink target (1)
//   while the block is idle.
// Sequence:
//   One request at a time. An add without eviction goes from dispatch to
//   the append state and then to the finish state. Fetch and unmark walk the
//   ring one slot per cycle through the registered memory read. Remove also
//   trims end holes one per cycle. An evicting add walks, trims, then
//   appends.
// Reset:
//   Clears the ring, the totals and the config registers; record memories
//   are not cleared, only slots marked valid are ever used.
// Stall:
//   A finished word waits in the output register; the block takes the next
//   request meanwhile and holds its result until the output register frees.
module marked_record_fifo_tracker
#(
    parameter int ENTRY_DEPTH = 64,
    parameter int SIZE_BITS   = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // func[1:0], record_size[17:2], bucket_tag[33:18], offer_len[49:34]
    input  logic [mrft_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status[1:0], out_size[17:2], out_bucket[33:18], slot[39:34],
    // evicted_count[46:40], unmarked_byte_total[70:47],
    // unmarked_record_total[77:71], occupied_byte_total[101:78]
    output logic [mrft_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [mrft_pkg::CFG_W-1:0]  cfg_data
);

    mrft_pkg::dp_cmd_t  cmd;
    mrft_pkg::dp_stat_t stat;
    logic               in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    mrft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrft_dp
    #(
        .ENTRY_DEPTH (ENTRY_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### sim/tb.sv
// Testbench for the marked record FIFO tracker: scoreboarded random and directed traffic.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    // Result word fields
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_size;
        logic [15:0] out_bucket;
        logic [5:0]  slot;
        logic [6:0]  evicted;
        logic [23:0] unmarked_bytes;
        logic [6:0]  unmarked_records;
        logic [23:0] occupied_bytes;
    } result_t;

    // Tracker predictor and store of expected results
    class tracker_scoreboard;
        logic [15:0] rec_size [DEPTH];
        logic [15:0] rec_bucket [DEPTH];
        bit          rec_marked [DEPTH];
        bit          rec_valid [DEPTH];
        int unsigned head, fill;
        int unsigned occ_bytes, unm_bytes, unm_recs;
        int unsigned max_bytes, shrink_bytes;
        result_t     pending_results[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                rec_marked[i] = 0;
                rec_valid[i] = 0;
            end
            head = 0; fill = 0;
            occ_bytes = 0; unm_bytes = 0; unm_recs = 0;
            max_bytes = 0; shrink_bytes = 0;
            errors = 0; checked = 0;
        endfunction

        function int unsigned pos(int unsigned k);
            return (head + k) % DEPTH;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            if (idx == mrft_pkg::CFG_MAX_BYTES)
                max_bytes = 32'(val);
            else if (idx == mrft_pkg::CFG_SHRINK_BYTES)
                shrink_bytes = 32'(val);
        endfunction

        function void trim();
            while (fill > 0 && !rec_valid[head])
            begin
                head = (head + 1) % DEPTH;
                fill--;
            end
            while (fill > 0 && !rec_valid[pos(fill - 1)])
                fill--;
        endfunction

        // Work out the result of one accepted request
        function void note_request(logic [1:0] func, logic [15:0] rsize,
                                   logic [15:0] bucket, logic [15:0] blen);
            result_t r;
            int unsigned s;
            bit hit;
            r = '0;
            hit = 0;
            if (func == mrft_pkg::FUNC_ADD)
            begin
                if (max_bytes != 0 && occ_bytes + rsize > max_bytes)
                begin
                    for (int unsigned k = 0; k < fill && occ_bytes > shrink_bytes; k++)
                    begin
                        s = pos(k);
                        if (rec_valid[s])
                        begin
                            occ_bytes -= rec_size[s];
                            if (!rec_marked[s])
                            begin
                                unm_bytes -= rec_size[s];
                                unm_recs--;
                            end
                            rec_valid[s] = 0;
                            rec_marked[s] = 0;
                            r.evicted++;
                        end
                    end
                    trim();
                end
                if (fill >= DEPTH)
                    r.status = mrft_pkg::STAT_FULL;
                else
                begin
                    s = pos(fill);
                    rec_size[s] = rsize;
                    rec_bucket[s] = bucket;
                    rec_marked[s] = 0;
                    rec_valid[s] = 1;
                    fill++;
                    occ_bytes += rsize;
                    unm_bytes += rsize;
                    unm_recs++;
                    r.slot = 6'(s);
                end
            end
            else if (func == mrft_pkg::FUNC_FETCH)
            begin
                r.status = mrft_pkg::STAT_MISS;
                for (int unsigned k = 0; k < fill; k++)
                begin
                    s = pos(k);
                    if (rec_valid[s] && !rec_marked[s])
                    begin
                        r.out_size = rec_size[s];
                        r.out_bucket = rec_bucket[s];
                        r.slot = 6'(s);
                        if (rec_size[s] > blen)
                            r.status = mrft_pkg::STAT_NOROOM;
                        else
                        begin
                            r.status = mrft_pkg::STAT_OK;
                            rec_marked[s] = 1;
                            unm_bytes -= rec_size[s];
                            unm_recs--;
                        end
                        break;
                    end
                end
            end
            else
            begin
                for (int unsigned k = 0; k < fill; k++)
                begin
                    s = pos(k);
                    if (rec_valid[s] && rec_marked[s] && rec_bucket[s] == bucket)
                    begin
                        hit = 1;
                        rec_marked[s] = 0;
                        if (func == mrft_pkg::FUNC_REMOVE)
                        begin
                            occ_bytes -= rec_size[s];
                            rec_valid[s] = 0;
                        end
                        else
                        begin
                            unm_bytes += rec_size[s];
                            unm_recs++;
                        end
                    end
                end
                if (func == mrft_pkg::FUNC_REMOVE)
                    trim();
                r.status = hit ? mrft_pkg::STAT_OK : mrft_pkg::STAT_MISS;
            end
            r.unmarked_bytes = (unm_bytes > 32'hFFFFFF) ? 24'hFFFFFF : 24'(unm_bytes);
            r.unmarked_records = (unm_recs > 127) ? 7'd127 : 7'(unm_recs);
            r.occupied_bytes = (occ_bytes > 32'hFFFFFF) ? 24'hFFFFFF : 24'(occ_bytes);
            pending_results.push_back(r);
        endfunction

        // Compare one result word with the oldest expectation
        task check_result(logic [mrft_pkg::OUT_W-1:0] data);
            result_t got, want;
            got.status           = data[1:0];
            got.out_size         = data[17:2];
            got.out_bucket       = data[33:18];
            got.slot             = data[39:34];
            got.evicted          = data[46:40];
            got.unmarked_bytes   = data[70:47];
            got.unmarked_records = data[77:71];
            got.occupied_bytes   = data[101:78];
            checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.out_size != want.out_size)
                report_mismatch("out_size", got.out_size, want.out_size);
            if (got.out_bucket != want.out_bucket)
                report_mismatch("out_bucket", got.out_bucket, want.out_bucket);
            if (got.slot != want.slot)
                report_mismatch("slot", got.slot, want.slot);
            if (got.evicted != want.evicted)
                report_mismatch("evicted_count", got.evicted, want.evicted);
            if (got.unmarked_bytes != want.unmarked_bytes)
                report_mismatch("unmarked_bytes", got.unmarked_bytes, want.unmarked_bytes);
            if (got.unmarked_records != want.unmarked_records)
                report_mismatch("unmarked_records", got.unmarked_records,
                                want.unmarked_records);
            if (got.occupied_bytes != want.occupied_bytes)
                report_mismatch("occupied_bytes", got.occupied_bytes, want.occupied_bytes);
        endtask

        task report_mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH word %0d %s: got %0d expected %0d",
                         checked, what, got, want);
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [mrft_pkg::IN_W-1:0]   s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [mrft_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [mrft_pkg::CFG_W-1:0]  cfg_data;

    tracker_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  words_sent;

    marked_record_fifo_tracker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Check words and note accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[1:0], s_axis_tdata[17:2],
                                s_axis_tdata[33:18], s_axis_tdata[49:34]);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d words outstanding", sb.pending_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Send one request word, with random idle before it
    task automatic send_word(logic [1:0] func, logic [15:0] rsize,
                             logic [15:0] bucket, logic [15:0] blen);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, blen, bucket, rsize, func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        release_bus();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Random request mix: mostly add/fetch with a small bucket set
    task automatic random_words(int count, int max_size);
        logic [1:0]  func;
        logic [15:0] rsize, bucket, blen;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            func = (pick < 40) ? mrft_pkg::FUNC_ADD : (pick < 70) ? mrft_pkg::FUNC_FETCH :
                   (pick < 85) ? mrft_pkg::FUNC_REMOVE : mrft_pkg::FUNC_UNMARK;
            rsize  = ($urandom_range(19) == 0) ? 16'($urandom) :
                     16'($urandom_range(max_size));
            bucket = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            blen   = ($urandom_range(4) == 0) ? 16'($urandom_range(max_size)) : 16'hFFFF;
            if ($urandom_range(15) == 0)
                blen = 16'($urandom);
            send_word(func, rsize, bucket, blen);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = mrft_pkg::CFG_MAX_BYTES;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        words_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store cases, extremes
        send_word(mrft_pkg::FUNC_FETCH, 16'd0, 16'd0, 16'hFFFF);
        send_word(mrft_pkg::FUNC_REMOVE, 16'd0, 16'd0, 16'd0);
        send_word(mrft_pkg::FUNC_UNMARK, 16'd0, 16'hFFFF, 16'd0);
        send_word(mrft_pkg::FUNC_ADD, 16'd0, 16'd0, 16'd0);
        send_word(mrft_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(mrft_pkg::FUNC_ADD, 16'h5555, 16'hAAAA, 16'h5555);
        send_word(mrft_pkg::FUNC_FETCH, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(mrft_pkg::FUNC_FETCH, 16'd0, 16'd0, 16'd0);
        send_word(mrft_pkg::FUNC_FETCH, 16'd0, 16'd0, 16'h0100);
        send_word(mrft_pkg::FUNC_FETCH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(mrft_pkg::FUNC_UNMARK, 16'd0, 16'hFFFF, 16'd0);
        send_word(mrft_pkg::FUNC_FETCH, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_word(mrft_pkg::FUNC_REMOVE, 16'd0, 16'hFFFF, 16'd0);
        send_word(mrft_pkg::FUNC_REMOVE, 16'd0, 16'h1234, 16'd0);
        wait_idle();

        // Fill the store past its depth to hit the full case
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(mrft_pkg::FUNC_ADD, 16'($urandom_range(255)),
                      16'($urandom_range(3)), 16'd0);
        wait_idle();

        // Unlimited store, four idling phases; hold-off in the first
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3 ? 8 : 0);
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3 ? 8 : 0);
            if (ph == 0)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            random_words(120, 255);
            if (ph == 2)
                random_words(120, 65535);
        end
        wait_idle();

        // Byte limits: small, extreme, shrink above limit, limit max, shrink just below limit
        write_reg(mrft_pkg::CFG_MAX_BYTES, 24'd2000);
        write_reg(mrft_pkg::CFG_SHRINK_BYTES, 24'd1000);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3 ? 8 : 0);
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3 ? 8 : 0);
            random_words(120, 300);
        end
        wait_idle();
        write_reg(mrft_pkg::CFG_MAX_BYTES, 24'd1);
        write_reg(mrft_pkg::CFG_SHRINK_BYTES, 24'd0);
        random_words(150, 3);
        wait_idle();
        write_reg(mrft_pkg::CFG_MAX_BYTES, 24'd100000);
        write_reg(mrft_pkg::CFG_SHRINK_BYTES, 24'hFFFFFF);
        random_words(150, 65535);
        wait_idle();
        write_reg(mrft_pkg::CFG_MAX_BYTES, 24'hFFFFFF);
        write_reg(mrft_pkg::CFG_SHRINK_BYTES, 24'h800000);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        random_words(200, 65535);
        wait_idle();
        write_reg(mrft_pkg::CFG_MAX_BYTES, 24'd5000);
        write_reg(mrft_pkg::CFG_SHRINK_BYTES, 24'd4999);
        random_words(150, 500);
        wait_idle();

        $display("sent %0d requests, checked %0d result words", words_sent, sb.checked);
        $display("covered adds with eviction, fetches, bucket remove/unmark, full store");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

### sim.f
rtl/core/mrft_pkg.sv
rtl/core/mrft_ctrl.sv
rtl/core/mrft_dp.sv
rtl/core/marked_record_fifo_tracker.sv
sim/tb.sv
